@@ rtl/core/occ_pkg.sv @@
package occ_pkg;

   localparam int MAX_OBSTACLES_DEFAULT = 64;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int POSE_WIDTH      = 24;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CELL_SIZE   = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HALF_SIZE   = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD   = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRID_SIDE   = 8'd3;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   localparam logic [6:0] OCCUPIED_VALUE = 7'd100;
   localparam logic [6:0] FREE_VALUE     = 7'd0;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] obstacle_x_mm;
      logic signed [15:0] obstacle_y_mm;
      logic [11:0]        cell_col;
      logic [11:0]        cell_row;
   } occ_req_type;

   typedef struct packed {
      logic [6:0] cell_value;
      logic [6:0] obstacle_count;
      logic       load_refused;
   } occ_rsp_type;

   typedef struct packed {
      logic [9:0]  cell_size_mm;
      logic [9:0]  obstacle_half_size_mm;
      logic [6:0]  occupied_threshold;
      logic [12:0] grid_side_cells;
   } occ_cfg_type;

   typedef struct packed {
      logic accept;     // latch request, apply clear or load
      logic pose_en;    // compute cell position, rewind scan
      logic scan_read;  // read table entry at scan index, advance
      logic load_out;   // move result into output register
   } occ_cmd_type;

   typedef struct packed {
      logic table_empty;
      logic scan_last;
      logic rsp_free;
   } occ_status_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_POSE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_RESP  = 5'b10000
   } occ_state_type;

endpackage

@@ rtl/core/occ_csr.sv @@
module occ_csr
   import occ_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output occ_cfg_type                cfg
);

   occ_cfg_type cfg_ff;
   occ_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CELL_SIZE: cfg_in.cell_size_mm          = csr_data[9:0];
            CSR_HALF_SIZE: cfg_in.obstacle_half_size_mm = csr_data[9:0];
            CSR_THRESHOLD: cfg_in.occupied_threshold    = csr_data[6:0];
            CSR_GRID_SIDE: cfg_in.grid_side_cells       = csr_data[12:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_size_mm          <= 10'd100;
         cfg_ff.obstacle_half_size_mm <= 10'd114;
         cfg_ff.occupied_threshold    <= 7'd25;
         cfg_ff.grid_side_cells       <= 13'd200;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/occ_ctrl.sv @@
module occ_ctrl
   import occ_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [1:0]     req_action,
   input  occ_status_type status,
   output occ_cmd_type    cmd
);

   occ_state_type state_ff;
   occ_state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_action == ACT_QUERY) ? ST_POSE : ST_RESP;
            end
         end
         ST_POSE: begin
            cmd.pose_en = 1'b1;
            state_in    = status.table_empty ? ST_RESP : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read lands and is compared this cycle
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/occ_dpath.sv @@
module occ_dpath
   import occ_pkg::*;
#(
   parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEFAULT
)
(
   input  logic           clock,
   input  logic           reset,
   input  occ_cfg_type    cfg,
   input  occ_req_type    req_payload,
   input  occ_cmd_type    cmd,
   output occ_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output occ_rsp_type    rsp_payload
);

   localparam int CW = $clog2(MAX_OBSTACLES + 1);
   localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_OBSTACLES);

   logic [31:0]         obstacle_table_ff [MAX_OBSTACLES];
   logic [31:0]         rd_data_ff;
   logic                rd_valid_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [1:0]          action_ff;
   logic                refused_ff;
   logic [11:0]         col_ff, row_ff;
   logic signed [POSE_WIDTH-1:0] px_ff, py_ff;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   occ_rsp_type         rsp_ff;

   logic [11:0]         half_cells;
   logic signed [12:0]  dx, dy;
   logic signed [10:0]  cell_size_s;
   logic signed [POSE_WIDTH-1:0] radius, ox, oy;
   logic signed [POSE_WIDTH-1:0] x_lo, x_hi, y_lo, y_hi;
   logic                entry_hit;
   logic                table_full;
   logic                occupied;

   assign table_full = (count_ff >= MAX_COUNT);

   // cell offset from grid center, scaled to millimeters
   assign half_cells  = cfg.grid_side_cells[12:1];
   assign dx          = $signed({1'b0, col_ff}) - $signed({1'b0, half_cells});
   assign dy          = $signed({1'b0, row_ff}) - $signed({1'b0, half_cells});
   assign cell_size_s = $signed({1'b0, cfg.cell_size_mm});

   // strict square test against the entry read last cycle
   assign radius = $signed(POSE_WIDTH'(cfg.obstacle_half_size_mm));
   assign ox     = POSE_WIDTH'($signed(rd_data_ff[15:0]));
   assign oy     = POSE_WIDTH'($signed(rd_data_ff[31:16]));
   assign x_lo   = ox - radius;
   assign x_hi   = ox + radius;
   assign y_lo   = oy - radius;
   assign y_hi   = oy + radius;
   assign entry_hit = (px_ff > x_lo) && (px_ff < x_hi) && (py_ff > y_lo) && (py_ff < y_hi);

   assign occupied = (action_ff == ACT_QUERY) && hit_ff
                     && (OCCUPIED_VALUE > cfg.occupied_threshold);

   always_comb begin
      count_in = count_ff;
      if (cmd.accept) begin
         case (req_payload.action)
            ACT_CLEAR: count_in = '0;
            ACT_LOAD:  count_in = table_full ? count_ff : count_ff + CW'(1);
            default:   count_in = count_ff;
         endcase
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.pose_en) begin
         idx_in = '0;
      end else if (cmd.scan_read) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_comb begin
      hit_in = hit_ff;
      if (cmd.pose_en) begin
         hit_in = 1'b0;
      end else if (rd_valid_ff && entry_hit) begin
         hit_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_valid_ff  <= cmd.scan_read;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      if (cmd.accept) begin
         action_ff  <= req_payload.action;
         refused_ff <= (req_payload.action == ACT_LOAD) && table_full;
         col_ff     <= req_payload.cell_col;
         row_ff     <= req_payload.cell_row;
      end
      if (cmd.pose_en) begin
         px_ff <= POSE_WIDTH'(cell_size_s * dx);
         py_ff <= POSE_WIDTH'(cell_size_s * dy);
      end
      if (cmd.load_out) begin
         rsp_ff.cell_value     <= occupied ? OCCUPIED_VALUE : FREE_VALUE;
         rsp_ff.obstacle_count <= 7'(count_ff);
         rsp_ff.load_refused   <= refused_ff;
      end
   end

   // obstacle table: one write port on load, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (cmd.accept && (req_payload.action == ACT_LOAD) && !table_full) begin
         obstacle_table_ff[count_ff[AW-1:0]] <= {req_payload.obstacle_y_mm,
                                                 req_payload.obstacle_x_mm};
      end
      if (cmd.scan_read) begin
         rd_data_ff <= obstacle_table_ff[idx_ff];
      end
   end

   assign status.table_empty = (count_ff == '0);
   assign status.scan_last   = (CW'(idx_ff) == count_ff - CW'(1));
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/core/occupancy_cell_classifier.sv @@
// Occupancy cell classifier: holds up to MAX_OBSTACLES obstacle positions and
// answers one result beat for every request beat.
// Request channel (req_): action 0 clears the table, 1 loads one obstacle,
// 2 queries a grid cell, 3 does nothing. A beat moves when req_valid is high
// and req_stall is low; req_stall is high while an item is in progress.
// Result channel (rsp_): cell_value (100 occupied, 0 free), the stored count
// and the refused flag for a load into a full table. rsp_valid comes from a
// register; hold rsp_stall high and the beat stays put.
// Configuration (csr_): index/data writes with valid/ready, ready always high;
// write only while the block is idle.
// Steps: clear, load and no-op go from accept straight to the result step. A
// query adds pose, scan and drain steps (no scan or drain on an empty table);
// the scan reads one entry per cycle through the single registered read port.
// The result appears the cycle after the item finishes, if the output
// register is free; a stalled result holds the block in its result step.
// Reset: synchronous; empties the table, restores register defaults
// (cell 100 mm, half side 114 mm, threshold 25, grid side 200 cells).
module occupancy_cell_classifier
   import occ_pkg::*;
#(
   parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  occ_req_type                req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output occ_rsp_type                rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   occ_cfg_type    cfg;
   occ_cmd_type    cmd;
   occ_status_type status;

   // register file
   occ_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // sequencer: accept, pose, scan, drain, respond
   occ_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_payload.action),
      .status     (status),
      .cmd        (cmd)
   );

   // table, pose math, compare and output register
   occ_dpath #(
      .MAX_OBSTACLES (MAX_OBSTACLES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ sim/occ_scoreboard_pkg.sv @@
package occ_scoreboard_pkg;

   import occ_pkg::*;

   class cell_answer_book;

      // register copies, reset values as the block comes out of reset
      logic [9:0]  cell_size_mm;
      logic [9:0]  obstacle_half_size_mm;
      logic [6:0]  occupied_threshold;
      logic [12:0] grid_side_cells;

      logic signed [15:0] obstacle_x [MAX_OBSTACLES_DEFAULT];
      logic signed [15:0] obstacle_y [MAX_OBSTACLES_DEFAULT];
      int unsigned        stored_count;

      occ_rsp_type pending_answers [$];
      int unsigned mismatches;

      function new();
         cell_size_mm          = 10'd100;
         obstacle_half_size_mm = 10'd114;
         occupied_threshold    = 7'd25;
         grid_side_cells       = 13'd200;
         stored_count          = 0;
         mismatches            = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] index,
                              logic [CSR_DATA_WIDTH-1:0] data);
         case (index)
            CSR_CELL_SIZE: cell_size_mm          = data[9:0];
            CSR_HALF_SIZE: obstacle_half_size_mm = data[9:0];
            CSR_THRESHOLD: occupied_threshold    = data[6:0];
            CSR_GRID_SIDE: grid_side_cells       = data[12:0];
            default: ;
         endcase
      endfunction

      // cell center in mm along one axis, grid centered on the origin
      function longint cell_mm(logic [11:0] index);
         longint offset;
         offset = longint'(index) - longint'(grid_side_cells >> 1);
         return longint'(cell_size_mm) * offset;
      endfunction

      function int pending();
         return pending_answers.size();
      endfunction

      function void record_request(occ_req_type item);
         occ_rsp_type answer;
         longint      px;
         longint      py;
         longint      ox;
         longint      oy;
         longint      reach;
         bit          hit;
         answer = '0;
         hit    = 1'b0;
         case (item.action)
            ACT_CLEAR: stored_count = 0;
            ACT_LOAD: begin
               if (stored_count < MAX_OBSTACLES_DEFAULT) begin
                  obstacle_x[stored_count] = item.obstacle_x_mm;
                  obstacle_y[stored_count] = item.obstacle_y_mm;
                  stored_count++;
               end else begin
                  answer.load_refused = 1'b1;
               end
            end
            ACT_QUERY: begin
               px    = cell_mm(item.cell_col);
               py    = cell_mm(item.cell_row);
               reach = longint'(obstacle_half_size_mm);
               for (int i = 0; i < stored_count; i++) begin
                  ox = longint'(obstacle_x[i]);
                  oy = longint'(obstacle_y[i]);
                  if (px > ox - reach && px < ox + reach &&
                      py > oy - reach && py < oy + reach) begin
                     hit = 1'b1;
                  end
               end
               // occupancy is 100 on a hit when the threshold is below 100, 0 otherwise
               if (hit && occupied_threshold < OCCUPIED_VALUE) begin
                  answer.cell_value = OCCUPIED_VALUE;
               end else begin
                  answer.cell_value = FREE_VALUE;
               end
            end
            default: ;
         endcase
         answer.obstacle_count = stored_count[6:0];
         pending_answers = {pending_answers, answer};
      endfunction

      function void compare_field(string field, logic [6:0] want, logic [6:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_answer(occ_rsp_type got);
         occ_rsp_type want;
         if (pending_answers.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual %p",
                     $time, got);
            mismatches++;
            return;
         end
         want = pending_answers.pop_front();
         compare_field("cell_value", want.cell_value, got.cell_value);
         compare_field("obstacle_count", want.obstacle_count, got.obstacle_count);
         compare_field("load_refused", {6'd0, want.load_refused}, {6'd0, got.load_refused});
      endfunction

   endclass

endpackage

@@ sim/occupancy_cell_classifier_tb.sv @@
module occupancy_cell_classifier_tb;

   import occ_pkg::*;
   import occ_scoreboard_pkg::*;

   // quiet cycles allowed before the watchdog declares a failure
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int PHASE_COUNT     = 12;

   // indexes that decode to no register
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_LOW = 8'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_TOP = 8'hFF;

   // action code with no operation behind it
   localparam logic [1:0] ACT_NONE = 2'd3;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   occ_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   occ_rsp_type rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data  = '0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned items_sent    = 0;
   int unsigned quiet_cycles  = 0;

   cell_answer_book answers;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   occupancy_cell_classifier i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // Receiver: stall at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Check every result beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         answers.check_answer(rsp_payload);
      end
   end

   // Watchdog: count cycles in which no channel moves a beat.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request beat, idling first at the sender's rate. Keep valid
   // high between back-to-back beats so it is never lowered and raised in one step.
   task automatic send_item(input occ_req_type item);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      answers.record_request(item);
      items_sent++;
   endtask

   // Drop valid and hold off until every expected result is in.
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (answers.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      answers.write_reg(index, data);
   endtask

   function automatic occ_req_type make_item(input logic [1:0] action,
                                             input logic signed [15:0] x,
                                             input logic signed [15:0] y,
                                             input logic [11:0] col,
                                             input logic [11:0] row);
      occ_req_type item;
      item.action        = action;
      item.obstacle_x_mm = x;
      item.obstacle_y_mm = y;
      item.cell_col      = col;
      item.cell_row      = row;
      return item;
   endfunction

   function automatic occ_req_type noise_item();
      return make_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                       12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
   endfunction

   // How many cells either side of the center still land inside 16-bit mm.
   function automatic int pick_span();
      int span;
      span = $urandom_range(2, 12);
      if (answers.cell_size_mm != 0 && span > 30000 / answers.cell_size_mm) begin
         span = 30000 / answers.cell_size_mm;
      end
      if (span < 1) begin
         span = 1;
      end
      return span;
   endfunction

   function automatic logic [11:0] near_index(input int span);
      int idx;
      idx = int'(answers.grid_side_cells >> 1) + int'($urandom_range(0, 2 * span)) - span;
      if (idx < 0) begin
         idx = 0;
      end
      if (idx > 4095) begin
         idx = 4095;
      end
      return idx[11:0];
   endfunction

   // Obstacle coordinate close to a cell center; often right on the square's edge.
   function automatic logic signed [15:0] near_obstacle(input logic [11:0] idx);
      longint mm;
      int     half;
      int     nudge;
      half = int'(answers.obstacle_half_size_mm);
      case ($urandom_range(0, 5))
         0:       nudge = half;
         1:       nudge = -half;
         2:       nudge = half - 1;
         default: nudge = int'($urandom_range(0, 2 * half + 4)) - half - 2;
      endcase
      mm = answers.cell_mm(idx) + nudge;
      if (mm < -32768) begin
         mm = -32768;
      end
      if (mm > 32767) begin
         mm = 32767;
      end
      return mm[15:0];
   endfunction

   // One map: clear (mostly), load obstacles or overfill the table, query nearby.
   task automatic run_sequence(input bit fill_table);
      int unsigned load_count;
      int unsigned query_count;
      int          span;
      int unsigned pick;
      logic [11:0] col;
      logic [11:0] row;
      span        = pick_span();
      load_count  = fill_table ? MAX_OBSTACLES_DEFAULT + $urandom_range(1, 4)
                               : $urandom_range(0, 10);
      query_count = $urandom_range(1, 8);
      if ($urandom_range(0, 9) != 0) begin
         send_item(make_item(ACT_CLEAR, 16'($urandom), 16'($urandom),
                             12'($urandom_range(0, 4095)),
                             12'($urandom_range(0, 4095))));
      end else begin
         send_item(noise_item());
      end
      repeat (load_count) begin
         col = near_index(span);
         row = near_index(span);
         send_item(make_item(ACT_LOAD, near_obstacle(col), near_obstacle(row),
                             12'($urandom_range(0, 4095)),
                             12'($urandom_range(0, 4095))));
      end
      repeat (query_count) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            send_item(make_item(ACT_QUERY, 16'($urandom), 16'($urandom),
                                near_index(span), near_index(span)));
         end else if (pick < 95) begin
            send_item(make_item(ACT_QUERY, 16'($urandom), 16'($urandom),
                                12'($urandom_range(0, 4095)),
                                12'($urandom_range(0, 4095))));
         end else begin
            send_item(noise_item());
         end
      end
   endtask

   // Directed beats at reset settings: 100 mm cells, half side 114, center cell 100.
   task automatic run_directed();
      send_item(make_item(ACT_QUERY, 16'sd0, 16'sd0, 12'd100, 12'd100));  // empty table
      send_item(make_item(ACT_NONE, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF)); // unused action
      send_item(make_item(ACT_LOAD, 16'sd113, 16'sd0, 12'd0, 12'd0));
      send_item(make_item(ACT_QUERY, 16'sd0, 16'sd0, 12'd100, 12'd100));  // just inside
      send_item(make_item(ACT_CLEAR, 16'sd0, 16'sd0, 12'd0, 12'd0));
      send_item(make_item(ACT_LOAD, 16'sd114, 16'sd0, 12'd0, 12'd0));
      send_item(make_item(ACT_QUERY, 16'sd0, 16'sd0, 12'd100, 12'd100));  // on the edge
      send_item(make_item(ACT_QUERY, 16'sd0, 16'sd0, 12'd101, 12'd100));
      send_item(make_item(ACT_LOAD, 16'sd0, -16'sd113, 12'hFFF, 12'hFFF));
      send_item(make_item(ACT_QUERY, 16'sd0, 16'sd0, 12'd100, 12'd100));
      send_item(make_item(ACT_LOAD, -16'sd32768, 16'sd32767, 12'd0, 12'd0));
      send_item(make_item(ACT_LOAD, 16'sd32767, -16'sd32768, 12'd0, 12'd0));
      send_item(make_item(ACT_QUERY, 16'sd0, 16'sd0, 12'd0, 12'd0));
      send_item(make_item(ACT_QUERY, 16'sd0, 16'sd0, 12'hFFF, 12'hFFF));
      send_item(make_item(ACT_QUERY, 16'sd0, 16'sd0, 12'd0, 12'hFFF));
      send_item(make_item(ACT_NONE, 16'sd0, 16'sd0, 12'd0, 12'd0));
      send_item(make_item(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF));
      send_item(make_item(ACT_QUERY, 16'sd0, 16'sd0, 12'd101, 12'd100));  // cleared
   endtask

   // Write all four registers, then drop the write valid.
   task automatic apply_setting(input logic [CSR_DATA_WIDTH-1:0] cell_size,
                                input logic [CSR_DATA_WIDTH-1:0] half,
                                input logic [CSR_DATA_WIDTH-1:0] threshold,
                                input logic [CSR_DATA_WIDTH-1:0] grid);
      write_csr(CSR_CELL_SIZE, cell_size);
      write_csr(CSR_HALF_SIZE, half);
      write_csr(CSR_THRESHOLD, threshold);
      write_csr(CSR_GRID_SIDE, grid);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [CSR_DATA_WIDTH-1:0] settings [PHASE_COUNT][4];
      int unsigned               mode;
      settings = '{
         '{16'd100,  16'd114,  16'd25,   16'd200},
         '{16'd1,    16'd0,    16'd0,    16'd2},
         '{16'd1000, 16'd1000, 16'd100,  16'd4096},
         '{16'd1023, 16'd1023, 16'd127,  16'd8191},
         '{16'd0,    16'd50,   16'd99,   16'd200},
         '{16'hFC64, 16'hFC72, 16'hFF99, 16'hE0C8},  // junk above each field
         '{16'd37,   16'd200,  16'd50,   16'd1},
         '{16'd250,  16'd7,    16'd24,   16'd0},
         '{16'd3,    16'd1,    16'd1,    16'd4095},
         '{16'd500,  16'd999,  16'd100,  16'd1000},
         '{16'd0,    16'd0,    16'd0,    16'd0},
         '{16'd0,    16'd0,    16'd0,    16'd0}
      };
      // last two settings are drawn at random
      for (int p = PHASE_COUNT - 2; p < PHASE_COUNT; p++) begin
         for (int f = 0; f < 4; f++) begin
            settings[p][f] = 16'($urandom);
         end
      end

      answers = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase != 0) begin
            // registers move only with the block idle
            wait_for_answers();
            if (phase == 5) begin
               write_csr(CSR_UNUSED_LOW, 16'hFFFF);
               write_csr(CSR_UNUSED_TOP, 16'($urandom));
            end
            apply_setting(settings[phase][0], settings[phase][1],
                          settings[phase][2], settings[phase][3]);
         end
         mode = phase % 4;
         case (mode)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 72;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 72;
            end
            default: begin
               send_idle_pct = 10;
               stall_pct     = 10;
            end
         endcase
         if (phase % 4 == 1) begin
            run_sequence(1'b1);
         end
         while (items_sent < (phase + 1) * ITEMS_PER_PHASE) begin
            run_sequence($urandom_range(0, 99) < 5);
         end
      end

      wait_for_answers();
      // catch any stray result beat
      repeat (10) @(posedge clock);
      if (answers.mismatches == 0 && answers.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
